### rtl/uart_baud_divisor_calc_core_macros.svh
// assertion macros for the baud divisor calculator
// expects clk and arst_n in the scope of every use
`ifndef UART_BAUD_DIVISOR_CALC_CORE_MACROS_SVH
`define UART_BAUD_DIVISOR_CALC_CORE_MACROS_SVH
`ifndef SYNTH
`define UBDC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ubdc assertion failed");
`define UBDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ubdc assertion failed");
`else
`define UBDC_ASSERT_IMPL(lbl, ante, cons)
`define UBDC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/ubdc_pkg.sv
// types and constants of the baud divisor calculator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ubdc_pkg;

	typedef enum logic [1:0] {
		MODE_ASYNC = 2'd0,
		MODE_SYNC  = 2'd1,
		MODE_IRDA  = 2'd2,
		MODE_SPI   = 2'd3
	} comm_mode_t;

	localparam logic [1:0] CFG_CLOCK_FREQUENCY = 2'd0;
	localparam logic [1:0] CFG_COMM_MODE       = 2'd1;
	localparam logic [1:0] CFG_DOUBLE_SPEED    = 2'd2;

	localparam logic [31:0] CLOCK_RESET = 32'd32000000;
	localparam logic [11:0] SEL_MASK    = 12'hfff;

	// limits of the exponent search, one per exponent -7 .. 6
	localparam logic [31:0] LIMIT_TABLE [0:13] = '{
		32'd255, 32'd511, 32'd1023, 32'd2047, 32'd4095, 32'd8190, 32'd16380,
		32'd32760, 32'd65520, 32'd131040, 32'd262080, 32'd524160, 32'd1048320,
		32'd2096640
	};

	// exponent offset by 7, so 0 .. 14
	localparam logic [3:0] EXP_OFFSET = 4'd7;

	typedef struct packed {
		logic        baud_zero;
		logic        is_async;
		logic        err;
		logic        ds_used;
		logic [31:0] rate;
	} front_side_t;

	typedef struct packed {
		logic        is_async;
		logic        err;
		logic        ds_used;
		logic [3:0]  e_off;
		logic [11:0] sync_div;
	} back_side_t;

	typedef struct packed {
		logic [11:0]       divisor;
		logic signed [3:0] scale_exponent;
		logic              double_speed_used;
		logic              error_code;
	} result_t;

endpackage
`default_nettype wire

### rtl/ubdc_pipe_div.sv
// pipelined restoring divider, one quotient bit per stage
// sideband travels with each item; no package dependency
`timescale 1ns / 1ps
`default_nettype none
module ubdc_pipe_div #(
	parameter int NW = 32,
	parameter int DW = 32,
	parameter int QW = 32,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side,
	output logic               out_valid,
	output logic [QW-1:0]      quo,
	output logic [SW-1:0]      out_side
);
	localparam int RW = DW + QW;

	logic [RW-1:0] rem_s  [0:QW];
	logic [DW-1:0] den_s  [0:QW];
	logic [QW-1:0] quo_s  [0:QW];
	logic [SW-1:0] side_s [0:QW];
	logic [QW:0]   valid_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= RW'(num);
			den_s[0]  <= den;
			quo_s[0]  <= '0;
			side_s[0] <= side;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic [RW-1:0] trial;
		logic          ge;

		always_comb begin
			trial = {den_s[j], {QW{1'b0}}} >> (j + 1);
			ge    = rem_s[j] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else if (en) begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? rem_s[j] - trial : rem_s[j];
				quo_s[j+1]  <= quo_s[j] | (ge ? (QW'(1) << (QW - 1 - j)) : '0);
				den_s[j+1]  <= den_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = valid_s[QW];
	assign quo       = quo_s[QW];
	assign out_side  = side_s[QW];

endmodule
`default_nettype wire

### rtl/uart_baud_divisor_calc_core.sv
// baud divisor calculator: input register, two divider pipelines, output register;
// one item per cycle while the skid buffer is empty, set by the two bit-per-stage
// divider pipelines (32 stages for clock/rate, 16 stages for the rounded divisor)
// a two-entry output register and skid buffer keep input ready off the output ready path
// asynchronous active-low reset clears valid bits and loads the configuration defaults
`timescale 1ns / 1ps
`default_nettype none
`include "uart_baud_divisor_calc_core_macros.svh"
module uart_baud_divisor_calc_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] baud_rate,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [11:0]      divisor,
	output logic signed [3:0] scale_exponent,
	output logic             double_speed_used,
	output logic             error_code
);
	import ubdc_pkg::*;

	logic [31:0] clock_frequency_q;
	comm_mode_t  comm_mode_q;
	logic        double_speed_request_q;

	logic        en;
	logic        v_s1;
	logic [31:0] baud_s1;

	front_side_t side1_in, side1_out;
	logic        div1_valid;
	logic [31:0] ratio;

	logic        v_s3;
	logic [31:0] ratio_s3;
	front_side_t side1_s3;
	logic [3:0]  e_off_s3;
	logic [3:0]  e_off_c;

	logic [41:0] num2, den2, rate_w, g_w, r_w;
	logic [30:0] half_ratio;
	back_side_t  side2_in, side2_out;
	logic        div2_valid;
	logic [15:0] quo2, adj2;

	result_t     tail, out_q, skid_q;
	logic        out_valid_q, skid_valid_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_frequency_q      <= CLOCK_RESET;
			comm_mode_q            <= MODE_ASYNC;
			double_speed_request_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_CLOCK_FREQUENCY: clock_frequency_q <= cfg_data;
				CFG_COMM_MODE: comm_mode_q <= comm_mode_t'(cfg_data[1:0]);
				CFG_DOUBLE_SPEED: double_speed_request_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign en       = !skid_valid_q;
	assign in_ready = en;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			baud_s1 <= baud_rate;
		end
	end

	// range check and rate doubling
	always_comb begin
		logic [31:0] rate_ceil, rate_floor;
		side1_in.is_async  = (comm_mode_q == MODE_ASYNC) || (comm_mode_q == MODE_IRDA);
		side1_in.ds_used   = (comm_mode_q == MODE_ASYNC) && double_speed_request_q;
		side1_in.baud_zero = baud_s1 == '0;
		rate_ceil  = side1_in.ds_used ? clock_frequency_q >> 3 : clock_frequency_q >> 4;
		rate_floor = side1_in.ds_used ? clock_frequency_q >> 22 : clock_frequency_q >> 23;
		side1_in.err = side1_in.is_async &&
			(side1_in.baud_zero || baud_s1 > rate_ceil || baud_s1 < rate_floor);
		side1_in.rate = (side1_in.is_async && !side1_in.ds_used) ?
			{baud_s1[30:0], 1'b0} : baud_s1;
	end

	ubdc_pipe_div #(
		.NW(32),
		.DW(32),
		.QW(32),
		.SW($bits(front_side_t))
	) u_ratio_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.num      (clock_frequency_q),
		.den      (side1_in.rate),
		.side     (side1_in),
		.out_valid(div1_valid),
		.quo      (ratio),
		.out_side (side1_out)
	);

	// exponent search
	always_comb begin
		e_off_c = 4'd14;
		for (int i = 13; i >= 0; i--) begin
			if (ratio < LIMIT_TABLE[i]) begin
				e_off_c = 4'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= div1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ratio_s3 <= ratio;
			side1_s3 <= side1_out;
			e_off_s3 <= e_off_c;
		end
	end

	// rounded divisor operands and sync result
	always_comb begin
		rate_w = 42'(side1_s3.rate);
		g_w    = 42'(clock_frequency_q) - (rate_w << 3);
		r_w    = rate_w << (e_off_s3 - 4'd4);
		if (e_off_s3 <= 4'd4) begin
			num2 = (g_w << (4'd4 - e_off_s3)) + (rate_w >> 1);
			den2 = rate_w;
		end else if (e_off_s3 < EXP_OFFSET) begin
			num2 = g_w + (r_w >> 1);
			den2 = r_w;
		end else begin
			num2 = 42'(clock_frequency_q) + (r_w >> 1);
			den2 = r_w;
		end
		half_ratio = ratio_s3[31:1];
		side2_in.is_async = side1_s3.is_async;
		side2_in.err      = side1_s3.err;
		side2_in.ds_used  = side1_s3.ds_used;
		side2_in.e_off    = e_off_s3;
		if (side1_s3.baud_zero) begin
			side2_in.sync_div = SEL_MASK;
		end else if (half_ratio == '0) begin
			side2_in.sync_div = '0;
		end else begin
			side2_in.sync_div = 12'(half_ratio - 31'd1);
		end
	end

	ubdc_pipe_div #(
		.NW(42),
		.DW(42),
		.QW(16),
		.SW($bits(back_side_t))
	) u_sel_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.num      (num2),
		.den      (den2),
		.side     (side2_in),
		.out_valid(div2_valid),
		.quo      (quo2),
		.out_side (side2_out)
	);

	// result assembly
	always_comb begin
		adj2 = (side2_out.e_off >= EXP_OFFSET) ? quo2 - 16'd1 : quo2;
		if (!side2_out.is_async) begin
			tail.divisor           = side2_out.sync_div;
			tail.scale_exponent    = '0;
			tail.double_speed_used = 1'b0;
			tail.error_code        = 1'b0;
		end else if (side2_out.err) begin
			tail.divisor           = '0;
			tail.scale_exponent    = '0;
			tail.double_speed_used = side2_out.ds_used;
			tail.error_code        = 1'b1;
		end else begin
			tail.divisor           = adj2[11:0];
			tail.scale_exponent    = 4'(side2_out.e_off - EXP_OFFSET);
			tail.double_speed_used = side2_out.ds_used;
			tail.error_code        = 1'b0;
		end
	end

	// output register and skid buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && out_ready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= div2_valid;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= div2_valid;
		end else if (en && div2_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && out_ready) begin
			out_q <= skid_valid_q ? skid_q : tail;
		end else if (!out_valid_q) begin
			out_q <= tail;
		end else if (en && div2_valid) begin
			skid_q <= tail;
		end
	end

	assign out_valid         = out_valid_q;
	assign divisor           = out_q.divisor;
	assign scale_exponent    = out_q.scale_exponent;
	assign double_speed_used = out_q.double_speed_used;
	assign error_code        = out_q.error_code;

	`UBDC_ASSERT_IMPL(a_skid_needs_out, skid_valid_q, out_valid_q)
	`UBDC_ASSERT_IMPL(a_skid_blocks_input, skid_valid_q, !in_ready)
	`UBDC_ASSERT_IMPL(a_error_zeroes, out_valid && error_code,
		divisor == '0 && scale_exponent == '0)
	`UBDC_ASSERT_IMPL(a_scale_range, out_valid, scale_exponent != 4'sb1000)
	`UBDC_ASSERT_IMPL(a_sync_plain,
		out_valid && (comm_mode_q == MODE_SYNC || comm_mode_q == MODE_SPI),
		!double_speed_used && !error_code && scale_exponent == '0)
	`UBDC_ASSERT_NEXT(a_skid_drains, skid_valid_q && out_ready, !skid_valid_q)

endmodule
`default_nettype wire
